### design/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg: shared types and constants for the polygon area/perimeter block
// Controller states, datapath operation codes, command/status bundles and
// the fixed field widths and saturation limits.
// ----------------------------------------------------------------------------
package pap_pkg;

  // field and accumulator widths
  localparam int COORD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int PROD_W  = 34;
  localparam int SQ_W    = 34;
  localparam int TERM_W  = 35;
  localparam int CROSS_W = 46;
  localparam int LEN_W   = 37;
  localparam int AREA_W  = 44;
  localparam int COUNT_W = 13;
  localparam int OUT_W   = 96;

  // saturation limits
  localparam logic signed [CROSS_W:0] CROSS_HI = 47'sd35184372088831;
  localparam logic signed [CROSS_W:0] CROSS_LO = -47'sd35184372088831;
  localparam logic [LEN_W-1:0]        LEN_MAX  = {LEN_W{1'b1}};
  localparam logic [CROSS_W-1:0]      AREA_MAX = {{(CROSS_W-AREA_W){1'b0}}, {AREA_W{1'b1}}};
  localparam int                      COUNT_CAP = 8191;

  // controller states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_MDX   = 11'b00000000010,
    ST_MDY   = 11'b00000000100,
    ST_MC1   = 11'b00000001000,
    ST_MC2   = 11'b00000010000,
    ST_CDIFF = 11'b00000100000,
    ST_CACC  = 11'b00001000000,
    ST_ROOT  = 11'b00010000000,
    ST_LACC  = 11'b00100000000,
    ST_ADV   = 11'b01000000000,
    ST_FIN   = 11'b10000000000
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_MDX,
    OP_MDY,
    OP_MC1,
    OP_MC2,
    OP_CDIFF,
    OP_CACC,
    OP_ROOT,
    OP_LACC,
    OP_ADV,
    OP_FINISH
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   closing;   // edge is (current, start) instead of (prior, current)
    logic   root_go;   // start the square root with the current edge
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic first_vertex;
    logic last;
    logic close_needed;
    logic root_last;
    logic out_free;
  } stat_t;

endpackage

### design/pap_sqrt.sv
// ----------------------------------------------------------------------------
// pap_sqrt: bit-serial integer square root
// Two radicand bits per cycle while step is high; returns floor(sqrt(radicand * 4^FRAC_BITS)).
// ----------------------------------------------------------------------------
module pap_sqrt
  import pap_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [SQ_W-1:0]               radicand,
  output logic [SQ_W/2+FRAC_BITS-1:0]   root,
  output logic                          last
);

  localparam int N     = SQ_W / 2 + FRAC_BITS;
  localparam int RADW  = 2 * N;
  localparam int CNT_W = $clog2(N);

  logic [RADW-1:0]  rad;
  logic [N+1:0]     rem;
  logic [CNT_W-1:0] cnt;
  logic [N+1:0]     rem_sh;
  logic [N+1:0]     trial;
  logic             fits;

  // one restoring digit step
  assign rem_sh = {rem[N-1:0], rad[RADW-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;
  assign last   = cnt == CNT_W'(N - 1);

  always_ff @(posedge clk) begin
    if (load) begin
      rad  <= RADW'(radicand) << (2 * FRAC_BITS);
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (step) begin
      rad  <= rad << 2;
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[N-2:0], fits};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

### design/pap_datapath.sv
// ----------------------------------------------------------------------------
// pap_datapath: vertex registers, shared multiplier, accumulators, output
// Executes one operation per cycle as ordered by the controller.
// ----------------------------------------------------------------------------
module pap_datapath
  import pap_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int FRAC_BITS    = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [31:0]       s_tdata,
  input  logic              s_tlast,
  input  logic              close_chain,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [OUT_W-1:0]  m_tdata
);

  localparam int RW        = SQ_W / 2 + FRAC_BITS;
  localparam int CAP       = (MAX_VERTICES + 1 < COUNT_CAP) ? MAX_VERTICES + 1 : COUNT_CAP;
  localparam int TOTAL_LIM = (MAX_VERTICES < COUNT_CAP) ? MAX_VERTICES : COUNT_CAP;

  // vertex registers
  logic signed [COORD_W-1:0] cur_x, cur_y, start_x, start_y, prior_x, prior_y;
  logic                      cur_last;
  logic [COUNT_W-1:0]        seen_count;

  // arithmetic registers
  logic signed [PROD_W-1:0]  prod, term_a;
  logic signed [TERM_W-1:0]  term;
  logic [SQ_W-1:0]           sq, first_edge_sq;
  logic signed [CROSS_W-1:0] cross_sum;
  logic [LEN_W-1:0]          length_sum;
  logic                      all_equal;

  // output register
  logic [AREA_W-1:0]  out_area;
  logic [LEN_W-1:0]   out_perim;
  logic               out_equal;
  logic [COUNT_W-1:0] out_total;
  logic               out_many;

  logic signed [COORD_W-1:0] ax, ay, bx, by;
  logic signed [DIFF_W-1:0]  dx, dy, mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_full;
  logic signed [CROSS_W:0]   cross_wide;
  logic [LEN_W:0]            len_wide;
  logic [CROSS_W-1:0]        area_mag;
  logic [RW-1:0]             root;
  logic                      root_last;
  logic                      edge_first;
  logic                      out_free;

  // edge endpoints: (prior, current) or closing (current, start)
  assign ax = cmd.closing ? cur_x : prior_x;
  assign ay = cmd.closing ? cur_y : prior_y;
  assign bx = cmd.closing ? start_x : cur_x;
  assign by = cmd.closing ? start_y : cur_y;
  assign dx = DIFF_W'(bx) - DIFF_W'(ax);
  assign dy = DIFF_W'(by) - DIFF_W'(ay);

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_MDX:  begin mul_a = dx;             mul_b = dx;             end
      OP_MDY:  begin mul_a = dy;             mul_b = dy;             end
      OP_MC1:  begin mul_a = DIFF_W'(ax);    mul_b = DIFF_W'(by);    end
      OP_MC2:  begin mul_a = DIFF_W'(ay);    mul_b = DIFF_W'(bx);    end
      default: begin mul_a = '0;             mul_b = '0;             end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // saturating sums
  assign cross_wide = (CROSS_W + 1)'(cross_sum) + (CROSS_W + 1)'(term);
  assign len_wide   = {1'b0, length_sum} + (LEN_W + 1)'(root);
  assign area_mag   = cross_sum[CROSS_W-1] ? CROSS_W'(-cross_sum) : CROSS_W'(cross_sum);
  assign edge_first = !cmd.closing && (seen_count == COUNT_W'(1));
  assign out_free   = !m_tvalid || m_tready;

  pap_sqrt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sqrt (
    .clk      (clk),
    .load     (cmd.op == OP_CACC && cmd.root_go),
    .step     (cmd.op == OP_ROOT),
    .radicand (sq),
    .root     (root),
    .last     (root_last)
  );

  // status back to the controller
  assign stat.first_vertex = seen_count == '0;
  assign stat.last         = cur_last;
  assign stat.close_needed = close_chain && (cur_x != start_x || cur_y != start_y);
  assign stat.root_last    = root_last;
  assign stat.out_free     = out_free;

  // chain state (control)
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x       <= '0;
      start_y       <= '0;
      prior_x       <= '0;
      prior_y       <= '0;
      seen_count    <= '0;
      cross_sum     <= '0;
      length_sum    <= '0;
      first_edge_sq <= '0;
      all_equal     <= 1'b1;
    end else begin
      case (cmd.op)
        OP_CACC: begin
          if (cross_wide > CROSS_HI) begin
            cross_sum <= CROSS_HI[CROSS_W-1:0];
          end else if (cross_wide < CROSS_LO) begin
            cross_sum <= CROSS_LO[CROSS_W-1:0];
          end else begin
            cross_sum <= cross_wide[CROSS_W-1:0];
          end
        end
        OP_LACC: begin
          length_sum <= (len_wide > {1'b0, LEN_MAX}) ? LEN_MAX : len_wide[LEN_W-1:0];
          if (edge_first) begin
            first_edge_sq <= sq;
          end else if (sq != first_edge_sq) begin
            all_equal <= 1'b0;
          end
        end
        OP_ADV: begin
          if (seen_count == '0) begin
            start_x <= cur_x;
            start_y <= cur_y;
          end
          prior_x <= cur_x;
          prior_y <= cur_y;
          if (seen_count < COUNT_W'(CAP)) begin
            seen_count <= seen_count + 1'b1;
          end
        end
        OP_FINISH: begin
          start_x       <= '0;
          start_y       <= '0;
          prior_x       <= '0;
          prior_y       <= '0;
          seen_count    <= '0;
          cross_sum     <= '0;
          length_sum    <= '0;
          first_edge_sq <= '0;
          all_equal     <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // input latch, products, edge square and cross term difference
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        cur_x    <= s_tdata[COORD_W-1:0];
        cur_y    <= s_tdata[2*COORD_W-1:COORD_W];
        cur_last <= s_tlast;
      end
      OP_MDX: prod <= mul_full;
      OP_MDY: begin
        prod <= mul_full;
        sq   <= SQ_W'(prod);
      end
      OP_MC1: begin
        prod <= mul_full;
        sq   <= sq + SQ_W'(prod);
      end
      OP_MC2: begin
        prod   <= mul_full;
        term_a <= prod;
      end
      OP_CDIFF: term <= TERM_W'(term_a) - TERM_W'(prod);
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      out_area  <= (area_mag > AREA_MAX) ? AREA_MAX[AREA_W-1:0] : area_mag[AREA_W-1:0];
      out_perim <= length_sum;
      out_equal <= all_equal;
      out_total <= (seen_count > COUNT_W'(TOTAL_LIM)) ? COUNT_W'(TOTAL_LIM) : seen_count;
      out_many  <= {19'd0, seen_count} > 32'(MAX_VERTICES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {out_many, out_total, out_equal, out_perim, out_area};

endmodule

### design/pap_ctrl.sv
// ----------------------------------------------------------------------------
// pap_ctrl: sequencing state machine
// Steps the datapath through latch, edge, cross term, root, advance and finish operations.
// ----------------------------------------------------------------------------
module pap_ctrl
  import pap_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  output logic   s_tready,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state, state_next;
  logic   closing, closing_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      closing <= 1'b0;
    end else begin
      state   <= state_next;
      closing <= closing_next;
    end
  end

  assign s_tready = state == ST_IDLE;

  // next state and command
  always_comb begin
    state_next   = state;
    closing_next = closing;
    cmd.op       = OP_NONE;
    cmd.closing  = closing;
    cmd.root_go  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op       = OP_LATCH;
          closing_next = 1'b0;
          state_next   = stat.first_vertex ? ST_ADV : ST_MDX;
        end
      end
      ST_MDX: begin
        cmd.op     = OP_MDX;
        state_next = ST_MDY;
      end
      ST_MDY: begin
        cmd.op     = OP_MDY;
        state_next = ST_MC1;
      end
      ST_MC1: begin
        cmd.op     = OP_MC1;
        state_next = ST_MC2;
      end
      ST_MC2: begin
        cmd.op     = OP_MC2;
        state_next = ST_CDIFF;
      end
      ST_CDIFF: begin
        cmd.op     = OP_CDIFF;
        state_next = ST_CACC;
      end
      ST_CACC: begin
        // closing edge adds to the perimeter only when enabled and not degenerate; its cross term is always accumulated
        cmd.op      = OP_CACC;
        cmd.root_go = !closing || stat.close_needed;
        if (cmd.root_go) begin
          state_next = ST_ROOT;
        end else begin
          state_next = closing ? ST_FIN : ST_ADV;
        end
      end
      ST_ROOT: begin
        cmd.op = OP_ROOT;
        if (stat.root_last) begin
          state_next = ST_LACC;
        end
      end
      ST_LACC: begin
        cmd.op     = OP_LACC;
        state_next = closing ? ST_FIN : ST_ADV;
      end
      ST_ADV: begin
        cmd.op = OP_ADV;
        if (stat.last) begin
          closing_next = 1'b1;
          state_next   = ST_MDX;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/polygon_area_perimeter.sv
// ----------------------------------------------------------------------------
// polygon_area_perimeter: shoelace area and perimeter of a vertex chain
//
//   channel  dir  handshake            content
//   s_*      in   s_tvalid / s_tready  one vertex, s_tlast marks the last one
//   m_*      out  m_tvalid / m_tready  area, perimeter, flags, count per chain
//   APB      in   psel/penable/pwrite  close_chain at byte address 0
//
// A vertex with an edge is latched, then passes the MDX, MDY, MC1, MC2, CDIFF,
// CACC, ROOT, LACC and ADV steps; the first vertex is only latched and advanced.
// The last vertex adds a closing pass through MDX to CACC, then ROOT and LACC if
// the closing edge is needed, and a finish step that waits for the result register.
// Synchronous active-high reset; close_chain resets to 1.
// The result register lets the next chain start while a result waits.
// ----------------------------------------------------------------------------
module polygon_area_perimeter
  import pap_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int FRAC_BITS    = 8
) (
  input  logic              clk,
  input  logic              rst,
  // vertex stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // [15:0] x_coord, [31:16] y_coord
  input  logic              s_tlast,   // last_vertex
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // [43:0] twice_area, [80:44] perimeter_fx,
                                       // [81] sides_equal, [94:82] vertex_total,
                                       // [95] too_many
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [2:0] ADDR_CLOSE_CHAIN = 3'h0;

  logic  close_chain;
  logic  sel_close;
  cmd_t  cmd;
  stat_t stat;

  // register decode
  assign pready    = 1'b1;
  assign sel_close = {paddr[2], 2'b00} == ADDR_CLOSE_CHAIN;
  assign prdata    = sel_close ? {31'd0, close_chain} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      close_chain <= 1'b1;
    end else if (psel && penable && pwrite && pready && sel_close) begin
      close_chain <= pwdata[0];
    end
  end

  pap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pap_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .close_chain (close_chain),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata)
  );

endmodule
